@@ rtl/core/e2q_pkg.sv @@
`default_nettype none

package e2q_pkg;

    localparam int POS_W  = 32;
    localparam int ANG_W  = 16;
    localparam int ARG_W  = 14;
    localparam int MAG_W  = 31;
    localparam int QUAT_W = 16;

    // angle codes in 1/128 degree of the half angle
    localparam logic [ANG_W-1:0] FULL_TURN      = 16'd46080;
    localparam logic [ANG_W-1:0] THREE_QUARTERS = 16'd34560;
    localparam logic [ANG_W-1:0] HALF_TURN      = 16'd23040;
    localparam logic [ARG_W-1:0] QUARTER_TURN   = 14'd11520;

    // round(pi * 2^30) = 23040 * PI_INT + PI_REM
    localparam logic [17:0] PI_INT = 18'd146408;
    localparam logic [14:0] PI_REM = 15'd19106;

    // 23040 = 512 * 45
    localparam logic [5:0]  DIV_45    = 6'd45;
    localparam int          RECIP_SH  = 25;
    localparam logic [19:0] RECIP_45  = 20'((64'd1 << 25) / 64'd45);

    localparam logic [MAG_W-1:0] ONE_Q30 = 31'h4000_0000;

    localparam int NITER = 7;
    localparam logic [7:0] TAYLOR_D [0:NITER-1] =
        '{8'd210, 8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};
    localparam logic [29:0] TAYLOR_M [0:NITER-1] = '{
        30'((64'd1 << 32) / 64'd210),
        30'((64'd1 << 32) / 64'd156),
        30'((64'd1 << 32) / 64'd110),
        30'((64'd1 << 32) / 64'd72),
        30'((64'd1 << 32) / 64'd42),
        30'((64'd1 << 32) / 64'd20),
        30'((64'd1 << 32) / 64'd6)
    };

    // register stages inside the quarter wave sine unit
    localparam int QS_LAT = 4 + 3 * NITER + 1;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } t_smag;

endpackage

`default_nettype wire

@@ rtl/core/e2q_quarter_sine.sv @@
`default_nettype none

module e2q_quarter_sine (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [e2q_pkg::ARG_W-1:0]    i_arg,
    output logic [e2q_pkg::MAG_W-1:0]    o_sine
);

    localparam int NIT = e2q_pkg::NITER;
    localparam logic [63:0] RND30 = 64'd1 << 29;

    logic [18:0] r_v1;
    logic [30:0] r_base1;
    logic [13:0] r_qe2;
    logic [18:0] r_v2;
    logic [30:0] r_base2;
    logic [30:0] r_x3;
    logic [19:0] w_rem3;

    logic [30:0] r_cx    [0:NIT];
    logic [31:0] r_cx2   [0:NIT];
    logic [30:0] r_cterm [0:NIT];
    logic [30:0] r_ax    [0:NIT-1];
    logic [31:0] r_ax2   [0:NIT-1];
    logic [31:0] r_ap    [0:NIT-1];
    logic [30:0] r_bx    [0:NIT-1];
    logic [31:0] r_bx2   [0:NIT-1];
    logic [31:0] r_bp    [0:NIT-1];
    logic [29:0] r_bq    [0:NIT-1];
    logic [39:0] w_rem   [0:NIT-1];
    logic [29:0] w_q     [0:NIT-1];
    logic [30:0] w_s;
    logic [30:0] r_sine;

    assign w_rem3 = 20'(r_v2) - 20'(r_qe2) * 20'(e2q_pkg::DIV_45);

    always_comb begin
        for (int i = 0; i < NIT; i++) begin
            w_rem[i] = 40'(r_bp[i]) - 40'(r_bq[i]) * 40'(e2q_pkg::TAYLOR_D[i]);
            w_q[i]   = r_bq[i] + 30'(w_rem[i] >= 40'(e2q_pkg::TAYLOR_D[i]));
        end
        w_s = 31'((64'(r_cx[NIT]) * 64'(r_cterm[NIT]) + RND30) >> 30);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // argument in radians, Q1.30
            r_v1    <= 19'((32'(i_arg) * 32'(e2q_pkg::PI_REM)
                           + 32'(e2q_pkg::QUARTER_TURN)) >> 9);
            r_base1 <= 31'(32'(i_arg) * 32'(e2q_pkg::PI_INT));

            r_qe2   <= 14'((40'(r_v1) * 40'(e2q_pkg::RECIP_45)) >> e2q_pkg::RECIP_SH);
            r_v2    <= r_v1;
            r_base2 <= r_base1;

            r_x3    <= r_base2 + 31'(r_qe2) + 31'(w_rem3 >= 20'(e2q_pkg::DIV_45));

            r_cx[0]    <= r_x3;
            r_cx2[0]   <= 32'((64'(r_x3) * 64'(r_x3) + RND30) >> 30);
            r_cterm[0] <= e2q_pkg::ONE_Q30;

            // Horner steps of the series, highest order first
            for (int i = 0; i < NIT; i++) begin
                r_ax[i]  <= r_cx[i];
                r_ax2[i] <= r_cx2[i];
                r_ap[i]  <= 32'((64'(r_cx2[i]) * 64'(r_cterm[i]) + RND30) >> 30);

                r_bx[i]  <= r_ax[i];
                r_bx2[i] <= r_ax2[i];
                r_bp[i]  <= r_ap[i];
                r_bq[i]  <= 30'((64'(r_ap[i]) * 64'(e2q_pkg::TAYLOR_M[i])) >> 32);

                r_cx[i+1]    <= r_bx[i];
                r_cx2[i+1]   <= r_bx2[i];
                r_cterm[i+1] <= e2q_pkg::ONE_Q30 - 31'(w_q[i]);
            end

            r_sine <= (w_s > e2q_pkg::ONE_Q30) ? e2q_pkg::ONE_Q30 : w_s;
        end
    end

    assign o_sine = r_sine;

endmodule

`default_nettype wire

@@ rtl/core/euler_to_quaternion.sv @@
`default_nettype none

// channel   direction  handshake            payload
// pose      in         i_valid / o_ready    i_pos_x/y/z, i_roll/pitch/yaw_angle
// result    out        o_valid / i_ready    o_out_x/y/z, o_quat_x/y/z/w
//
// One pose per cycle while the output is not stalled.
// Depth is set by the 7-step series in the quarter wave sine pipeline
// (3 stages per step) plus angle reduction and the product/rounding stages.
// Reset clears only the valid bits. All stages hold when the output is full
// and not taken.

module euler_to_quaternion #(
    parameter int QUAT_FRAC_BITS = 15
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [e2q_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [e2q_pkg::POS_W-1:0]   i_pos_y,
    input  logic signed [e2q_pkg::POS_W-1:0]   i_pos_z,
    input  logic signed [e2q_pkg::ANG_W-1:0]   i_roll_angle,
    input  logic signed [e2q_pkg::ANG_W-1:0]   i_pitch_angle,
    input  logic signed [e2q_pkg::ANG_W-1:0]   i_yaw_angle,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [e2q_pkg::POS_W-1:0]   o_out_x,
    output logic signed [e2q_pkg::POS_W-1:0]   o_out_y,
    output logic signed [e2q_pkg::POS_W-1:0]   o_out_z,
    output logic signed [e2q_pkg::QUAT_W-1:0]  o_quat_x,
    output logic signed [e2q_pkg::QUAT_W-1:0]  o_quat_y,
    output logic signed [e2q_pkg::QUAT_W-1:0]  o_quat_z,
    output logic signed [e2q_pkg::QUAT_W-1:0]  o_quat_w
);

    localparam int QL = e2q_pkg::QS_LAT;
    localparam int NS = 2 + QL + 4;
    localparam int SH = 30 - QUAT_FRAC_BITS;
    localparam logic [33:0] RND_OUT = 34'((64'd1 << SH) >> 1);

    logic          adv;
    logic [NS-1:0] r_vld;

    logic [e2q_pkg::POS_W-1:0] r_px [0:NS-1];
    logic [e2q_pkg::POS_W-1:0] r_py [0:NS-1];
    logic [e2q_pkg::POS_W-1:0] r_pz [0:NS-1];

    logic [e2q_pkg::ANG_W-1:0] r_ang   [0:2];
    logic [e2q_pkg::ANG_W-1:0] w_t     [0:2];
    logic [16:0]               w_wrap  [0:2];
    logic [1:0]                w_q     [0:2];
    logic [e2q_pkg::ANG_W-1:0] w_qbase [0:2];
    logic [e2q_pkg::ARG_W-1:0] w_r     [0:2];
    logic [e2q_pkg::ARG_W-1:0] r_arg_s [0:2];
    logic [e2q_pkg::ARG_W-1:0] r_arg_c [0:2];
    logic [1:0]                r_quad  [0:QL][0:2];

    logic [e2q_pkg::MAG_W-1:0] w_smag [0:2];
    logic [e2q_pkg::MAG_W-1:0] w_cmag [0:2];
    e2q_pkg::t_smag            w_sn   [0:2];
    e2q_pkg::t_smag            w_cs   [0:2];

    e2q_pkg::t_smag r_pa, r_pb, r_pc, r_pd, r_cy, r_sy;
    logic signed [31:0] r_t   [0:7];
    logic signed [32:0] r_sum [0:3];
    logic [e2q_pkg::QUAT_W-1:0] r_quat [0:3];

    function automatic e2q_pkg::t_smag mul_q30(e2q_pkg::t_smag a, e2q_pkg::t_smag b);
        e2q_pkg::t_smag p;
        p.mag = 31'((64'(a.mag) * 64'(b.mag) + (64'd1 << 29)) >> 30);
        p.neg = a.neg ^ b.neg;
        return p;
    endfunction

    function automatic logic signed [31:0] to_signed(e2q_pkg::t_smag a);
        logic [31:0] m;
        m = 32'(a.mag);
        return a.neg ? -m : m;
    endfunction

    function automatic logic [15:0] quantize(logic signed [32:0] v);
        logic [32:0] m;
        logic [33:0] mr;
        logic [15:0] res;
        m  = v[32] ? -v : v;
        mr = (34'(m) + RND_OUT) >> SH;
        if (v[32]) begin
            res = (mr > 34'd32768) ? 16'h8000 : 16'(34'd0 - mr);
        end else begin
            res = (mr > 34'd32767) ? 16'h7fff : 16'(mr);
        end
        return res;
    endfunction

    assign adv     = !r_vld[NS-1] || i_ready;
    assign o_ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
        end
    end

    // half angle reduced to [0, 360) degrees, then quadrant and remainder
    always_comb begin
        for (int g = 0; g < 3; g++) begin
            w_wrap[g] = {r_ang[g][e2q_pkg::ANG_W-1], r_ang[g]} + 17'(e2q_pkg::FULL_TURN);
            w_t[g]    = r_ang[g][e2q_pkg::ANG_W-1] ? w_wrap[g][15:0] : r_ang[g];
            if (w_t[g] >= e2q_pkg::THREE_QUARTERS) begin
                w_q[g] = 2'd3;
                w_qbase[g] = e2q_pkg::THREE_QUARTERS;
            end else if (w_t[g] >= e2q_pkg::HALF_TURN) begin
                w_q[g] = 2'd2;
                w_qbase[g] = e2q_pkg::HALF_TURN;
            end else if (w_t[g] >= 16'(e2q_pkg::QUARTER_TURN)) begin
                w_q[g] = 2'd1;
                w_qbase[g] = 16'(e2q_pkg::QUARTER_TURN);
            end else begin
                w_q[g] = 2'd0;
                w_qbase[g] = '0;
            end
            w_r[g] = 14'(w_t[g] - w_qbase[g]);
        end
    end

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_trig
            e2q_quarter_sine u_sin (
                .i_clk  (i_clk),
                .i_en   (adv),
                .i_arg  (r_arg_s[g]),
                .o_sine (w_smag[g])
            );
            e2q_quarter_sine u_cos (
                .i_clk  (i_clk),
                .i_en   (adv),
                .i_arg  (r_arg_c[g]),
                .o_sine (w_cmag[g])
            );
        end
    endgenerate

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_sn[k].neg = r_quad[QL][k][1];
            w_sn[k].mag = r_quad[QL][k][0] ? w_cmag[k] : w_smag[k];
            w_cs[k].neg = r_quad[QL][k][1] ^ r_quad[QL][k][0];
            w_cs[k].mag = r_quad[QL][k][0] ? w_smag[k] : w_cmag[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_px[0] <= i_pos_x;
            r_py[0] <= i_pos_y;
            r_pz[0] <= i_pos_z;
            for (int s = 1; s < NS; s++) begin
                r_px[s] <= r_px[s-1];
                r_py[s] <= r_py[s-1];
                r_pz[s] <= r_pz[s-1];
            end

            r_ang[0] <= i_roll_angle;
            r_ang[1] <= i_pitch_angle;
            r_ang[2] <= i_yaw_angle;

            for (int k = 0; k < 3; k++) begin
                r_arg_s[k]   <= w_r[k];
                r_arg_c[k]   <= e2q_pkg::QUARTER_TURN - w_r[k];
                r_quad[0][k] <= w_q[k];
                for (int s = 1; s <= QL; s++) begin
                    r_quad[s][k] <= r_quad[s-1][k];
                end
            end

            // roll 0, pitch 1, yaw 2
            r_pa <= mul_q30(w_sn[0], w_cs[1]);
            r_pb <= mul_q30(w_cs[0], w_sn[1]);
            r_pc <= mul_q30(w_cs[0], w_cs[1]);
            r_pd <= mul_q30(w_sn[0], w_sn[1]);
            r_cy <= w_cs[2];
            r_sy <= w_sn[2];

            r_t[0] <= to_signed(mul_q30(r_pa, r_cy));
            r_t[1] <= to_signed(mul_q30(r_pb, r_sy));
            r_t[2] <= to_signed(mul_q30(r_pb, r_cy));
            r_t[3] <= to_signed(mul_q30(r_pa, r_sy));
            r_t[4] <= to_signed(mul_q30(r_pc, r_sy));
            r_t[5] <= to_signed(mul_q30(r_pd, r_cy));
            r_t[6] <= to_signed(mul_q30(r_pc, r_cy));
            r_t[7] <= to_signed(mul_q30(r_pd, r_sy));

            r_sum[0] <= 33'(r_t[0]) - 33'(r_t[1]);
            r_sum[1] <= 33'(r_t[2]) + 33'(r_t[3]);
            r_sum[2] <= 33'(r_t[4]) - 33'(r_t[5]);
            r_sum[3] <= 33'(r_t[6]) + 33'(r_t[7]);

            for (int k = 0; k < 4; k++) begin
                r_quat[k] <= quantize(r_sum[k]);
            end
        end
    end

    assign o_valid  = r_vld[NS-1];
    assign o_out_x  = r_px[NS-1];
    assign o_out_y  = r_py[NS-1];
    assign o_out_z  = r_pz[NS-1];
    assign o_quat_x = r_quat[0];
    assign o_quat_y = r_quat[1];
    assign o_quat_z = r_quat[2];
    assign o_quat_w = r_quat[3];

endmodule

`default_nettype wire

@@ tb/sv/pose_quat_checker.sv @@
`timescale 1ns / 100ps

module pose_quat_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic                               i_ready_in,
    input  logic signed [e2q_pkg::POS_W-1:0]   i_pos_x,
    input  logic signed [e2q_pkg::POS_W-1:0]   i_pos_y,
    input  logic signed [e2q_pkg::POS_W-1:0]   i_pos_z,
    input  logic signed [e2q_pkg::ANG_W-1:0]   i_roll,
    input  logic signed [e2q_pkg::ANG_W-1:0]   i_pitch,
    input  logic signed [e2q_pkg::ANG_W-1:0]   i_yaw,
    input  logic                               i_res_valid,
    input  logic                               i_res_ready,
    input  logic signed [e2q_pkg::POS_W-1:0]   i_out_x,
    input  logic signed [e2q_pkg::POS_W-1:0]   i_out_y,
    input  logic signed [e2q_pkg::POS_W-1:0]   i_out_z,
    input  logic signed [e2q_pkg::QUAT_W-1:0]  i_quat_x,
    input  logic signed [e2q_pkg::QUAT_W-1:0]  i_quat_y,
    input  logic signed [e2q_pkg::QUAT_W-1:0]  i_quat_z,
    input  logic signed [e2q_pkg::QUAT_W-1:0]  i_quat_w,
    output int                                 o_fail_cnt,
    output int                                 o_pending,
    output int                                 o_pose_cnt,
    output int                                 o_quat_cnt
);

    localparam int FRAC_BITS = 15;
    localparam longint ONE = 64'sd1 << 30;
    localparam longint HALF = 64'sd1 << 29;

    typedef struct packed {
        logic [31:0] x, y, z;
        logic [15:0] qx, qy, qz, qw;
    } t_pose_quat;

    t_pose_quat quat_fifo[$];

    function automatic longint qwave_sine(longint r);
        longint x, x2, term, s;
        x = (r * 64'sd3373259426 + 11520) / 23040;
        x2 = (x * x + HALF) >>> 30;
        term = ONE;
        for (int k = 7; k >= 1; k--)
            term = ONE - ((x2 * term + HALF) >>> 30) / (2 * k * (2 * k + 1));
        s = (x * term + HALF) >>> 30;
        return (s > ONE) ? ONE : s;
    endfunction

    function automatic void half_sin_cos(logic signed [15:0] a, output longint sn,
                                         output longint cs);
        int t, q, r;
        longint s, c;
        t = ((int'(a) % 46080) + 46080) % 46080;
        q = t / 11520;
        r = t % 11520;
        s = qwave_sine(r);
        c = qwave_sine(11520 - r);
        case (q)
            0: begin sn = s;  cs = c;  end
            1: begin sn = c;  cs = -s; end
            2: begin sn = -s; cs = -c; end
            default: begin sn = -c; cs = s; end
        endcase
    endfunction

    function automatic longint q30_mul(longint a, longint b);
        longint ma, mb, p;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        p = (ma * mb + HALF) >>> 30;
        return ((a < 0) != (b < 0)) ? -p : p;
    endfunction

    function automatic logic [15:0] q30_to_q15(longint v);
        longint m;
        int sh;
        sh = 30 - FRAC_BITS;
        m = (v < 0) ? -v : v;
        if (sh > 0)
            m = (m + (64'sd1 << (sh - 1))) >>> sh;
        if (v < 0)
            return (m > 32768) ? 16'h8000 : 16'(-m);
        return (m > 32767) ? 16'h7fff : 16'(m);
    endfunction

    function automatic t_pose_quat pose_to_quat(logic [31:0] px, py, pz,
                                                logic signed [15:0] ro, pi, ya);
        longint sr, cr, sp, cp, sy, cy;
        t_pose_quat e;
        half_sin_cos(ro, sr, cr);
        half_sin_cos(pi, sp, cp);
        half_sin_cos(ya, sy, cy);
        e.x = px;
        e.y = py;
        e.z = pz;
        e.qx = q30_to_q15(q30_mul(q30_mul(sr, cp), cy) - q30_mul(q30_mul(cr, sp), sy));
        e.qy = q30_to_q15(q30_mul(q30_mul(cr, sp), cy) + q30_mul(q30_mul(sr, cp), sy));
        e.qz = q30_to_q15(q30_mul(q30_mul(cr, cp), sy) - q30_mul(q30_mul(sr, sp), cy));
        e.qw = q30_to_q15(q30_mul(q30_mul(cr, cp), cy) + q30_mul(q30_mul(sr, sp), sy));
        return e;
    endfunction

    assign o_pending = quat_fifo.size();

    always @(posedge i_clk) begin
        t_pose_quat e, got;
        if (i_rst_n && i_valid && i_ready_in) begin
            quat_fifo.push_back(pose_to_quat(i_pos_x, i_pos_y, i_pos_z,
                                             i_roll, i_pitch, i_yaw));
            o_pose_cnt++;
        end
        if (i_rst_n && i_res_valid && i_res_ready) begin
            o_quat_cnt++;
            got = {i_out_x, i_out_y, i_out_z, i_quat_x, i_quat_y, i_quat_z, i_quat_w};
            if (quat_fifo.size() == 0) begin
                o_fail_cnt++;
                if (o_fail_cnt <= 10)
                    $display("unexpected result transaction: %h", got);
            end else begin
                e = quat_fifo.pop_front();
                if (e != got) begin
                    o_fail_cnt++;
                    if (o_fail_cnt <= 10)
                        $display("mismatch pos %h/%h %h/%h %h/%h quat %h/%h %h/%h %h/%h %h/%h",
                                 e.x, got.x, e.y, got.y, e.z, got.z, e.qx, got.qx,
                                 e.qy, got.qy, e.qz, got.qz, e.qw, got.qw);
                end
            end
        end
    end

endmodule

@@ tb/sv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    localparam int RAND_POSES = 900;
    localparam int STALL_LIMIT = 5000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        pose_valid = 1'b0;
    logic        pose_ready;
    logic [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic [15:0] roll = '0, pitch = '0, yaw = '0;
    logic        quat_valid;
    logic        quat_ready = 1'b0;
    logic signed [31:0] out_x, out_y, out_z;
    logic signed [15:0] quat_x, quat_y, quat_z, quat_w;
    int          fail_cnt, pending, pose_cnt, quat_cnt;
    int          idle_cycles = 0;
    bit          stim_done = 1'b0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    euler_to_quaternion u_top (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(pose_valid), .o_ready(pose_ready),
        .i_pos_x(pos_x), .i_pos_y(pos_y), .i_pos_z(pos_z),
        .i_roll_angle(roll), .i_pitch_angle(pitch), .i_yaw_angle(yaw),
        .o_valid(quat_valid), .i_ready(quat_ready),
        .o_out_x(out_x), .o_out_y(out_y), .o_out_z(out_z),
        .o_quat_x(quat_x), .o_quat_y(quat_y), .o_quat_z(quat_z), .o_quat_w(quat_w)
    );

    pose_quat_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(pose_valid), .i_ready_in(pose_ready),
        .i_pos_x(pos_x), .i_pos_y(pos_y), .i_pos_z(pos_z),
        .i_roll(roll), .i_pitch(pitch), .i_yaw(yaw),
        .i_res_valid(quat_valid), .i_res_ready(quat_ready),
        .i_out_x(out_x), .i_out_y(out_y), .i_out_z(out_z),
        .i_quat_x(quat_x), .i_quat_y(quat_y), .i_quat_z(quat_z), .i_quat_w(quat_w),
        .o_fail_cnt(fail_cnt), .o_pending(pending),
        .o_pose_cnt(pose_cnt), .o_quat_cnt(quat_cnt)
    );

    // receiver: alternating stretches of free flow, random and heavy stalls
    always @(negedge clk) begin
        int mode, left;
        if (left <= 0) begin
            mode = $urandom_range(0, 2);
            left = $urandom_range(5, 120);
        end
        left--;
        case (mode)
            0: quat_ready <= 1'b1;
            1: quat_ready <= ($urandom_range(0, 1) == 1);
            default: quat_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge clk) begin
        if ((pose_valid && pose_ready) || (quat_valid && quat_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("euler_to_quaternion regression: fail");
            $finish;
        end
    end

    function automatic logic [15:0] rand_angle();
        case ($urandom_range(0, 5))
            0: return 16'($urandom_range(0, 46080) - 23040);
            1: return 16'($urandom);
            2: return 16'(11520 * $urandom_range(0, 8) - 46080 + $urandom_range(0, 2) - 1);
            default: return 16'($urandom_range(0, 46080) - 23040);
        endcase
    endfunction

    task automatic send_pose(logic [31:0] x, y, z, logic [15:0] r, p, w);
        pos_x <= x;
        pos_y <= y;
        pos_z <= z;
        roll <= r;
        pitch <= p;
        yaw <= w;
        pose_valid <= 1'b1;
        do @(posedge clk); while (!pose_ready);
        @(negedge clk);
    endtask

    task automatic rest(int n);
        pose_valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    initial begin
        logic [15:0] corner [8];
        int burst;
        corner = '{16'sd0, 16'sd23040, -16'sd23040, 16'sd5760, -16'sd5760,
                   16'sd11520, 16'h7fff, 16'h8000};
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        send_pose('0, '0, '0, '0, '0, '0);
        send_pose(32'hffff_ffff, 32'h8000_0000, 32'h7fff_ffff, 16'sd23040, '0, '0);
        send_pose(32'h5555_5555, 32'haaaa_aaaa, '0, '0, 16'sd23040, '0);
        send_pose('0, '0, '0, '0, '0, -16'sd23040);
        for (int i = 0; i < 8; i++) begin
            send_pose($urandom, $urandom, $urandom, corner[i], corner[(i + 3) % 8],
                      corner[(i + 5) % 8]);
            if (i % 3 == 0)
                rest($urandom_range(1, 3));
        end
        send_pose('0, '0, '0, 16'sd11520, 16'sd11520, 16'sd11520);
        send_pose('0, '0, '0, 16'h7fff, 16'h8000, 16'h0001);
        for (int i = 0; i < RAND_POSES; i += burst) begin
            burst = $urandom_range(1, 40);
            for (int j = 0; j < burst; j++)
                send_pose($urandom, $urandom, $urandom, rand_angle(), rand_angle(),
                          rand_angle());
            if ($urandom_range(0, 3) != 0)
                rest($urandom_range(1, 12));
        end
        pose_valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        $display("covered %0d poses and %0d quaternion results, angle corners and wraps",
                 pose_cnt, quat_cnt);
        if (fail_cnt == 0)
            $display("euler_to_quaternion regression: pass");
        else
            $display("euler_to_quaternion regression: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/e2q_pkg.sv
rtl/core/e2q_quarter_sine.sv
rtl/core/euler_to_quaternion.sv
tb/sv/pose_quat_checker.sv
tb/sv/testbench.sv
